// ----- src/swdk_pkg.sv -----
// Package for the swerve drive kinematics block: fixed-point constants,
// sequencer state type and the CORDIC arctangent table.
// No dependencies.
package swdk_pkg;

  localparam int CordicStepsDef = 16;
  localparam int VW = 34;  // datapath width of the CORDIC and multiplier operands

  localparam logic [15:0] HoldTicksRst = 16'd500;
  localparam logic [29:0] InvKQ30 = 30'd652032874;
  localparam logic [29:0] ISq2Q30 = 30'd759250125;
  localparam logic signed [VW-1:0] Deg90  = 34'sd589824000;
  localparam logic signed [VW-1:0] Deg180 = 34'sd1179648000;
  localparam logic signed [VW-1:0] Deg360 = 34'sd2359296000;
  localparam logic signed [17:0] SpeedMax = 18'sd8500;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TWRAP, ST_TQUAD, ST_TITER, ST_TMX, ST_TMY, ST_QMUL,
    ST_MLOAD, ST_MPRE, ST_MITER, ST_MLEN, ST_MFIN, ST_OUT
  } state_e;

  function automatic logic signed [VW-1:0] atan_lut(input logic [4:0] i);
    logic signed [VW-1:0] r;
    begin
      unique case (i)
        5'd0:  r = 34'sd294912000;
        5'd1:  r = 34'sd174096719;
        5'd2:  r = 34'sd91987925;
        5'd3:  r = 34'sd46694507;
        5'd4:  r = 34'sd23437865;
        5'd5:  r = 34'sd11730358;
        5'd6:  r = 34'sd5866610;
        5'd7:  r = 34'sd2933484;
        5'd8:  r = 34'sd1466765;
        5'd9:  r = 34'sd733385;
        5'd10: r = 34'sd366693;
        5'd11: r = 34'sd183346;
        5'd12: r = 34'sd91673;
        5'd13: r = 34'sd45837;
        5'd14: r = 34'sd22918;
        5'd15: r = 34'sd11459;
        5'd16: r = 34'sd5730;
        5'd17: r = 34'sd2865;
        5'd18: r = 34'sd1432;
        5'd19: r = 34'sd716;
        5'd20: r = 34'sd358;
        5'd21: r = 34'sd179;
        5'd22: r = 34'sd90;
        5'd23: r = 34'sd45;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- src/swerve_drive_kinematics.sv -----
// Swerve drive inverse kinematics, four modules, one shared CORDIC and multiplier.
// Depends on swdk_pkg.
//
//  channel | dir | handshake                     | beat contents
//  s_axis  | in  | s_axis_tvalid/s_axis_tready   | one control tick of stick/heading
//  m_axis  | out | m_axis_tvalid/m_axis_tready   | four steer angles, four speeds
//  cfg     | in  | cfg_valid_i/cfg_ready_o       | hold_ticks
//
// A moving tick makes one field rotation and four atan2/length passes; all of
// them share one CORDIC stage and one multiplier. A stationary tick that is
// not held skips the field rotation, and each module whose vector is zero
// skips its CORDIC pass.
// A held tick produces no beat; the sequencer stays idle.
// Input is taken only while the sequencer is idle; a waiting result beat
// stays in the output register while the next tick is accepted, and the
// sequencer stalls in its last state while that beat is still waiting.
// Reset loads hold_ticks=500 and the initial flip/direction pattern.
module swerve_drive_kinematics #(
  parameter int CORDIC_STEPS = swdk_pkg::CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // stick_lx[10:0], stick_ly[21:11], stick_rx[32:22], spin_level[34:33],
  // heading[50:35], zero fill
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // steer_angle_1..4 [15:0],[31:16],[47:32],[63:48], wheel_speed_1..4
  // [78:64],[93:79],[108:94],[123:109], zero fill
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);
  import swdk_pkg::*;

  localparam int CntW = $clog2(CORDIC_STEPS);
  localparam logic [CntW-1:0] CntLast = CntW'(CORDIC_STEPS - 1);

  state_e state_q, state_d;

  logic signed [VW-1:0] x_q, y_q, z_q, fx_q, fy_q, q_q, len_q;
  logic signed [15:0]   spin_q, dir_q;
  logic [CntW-1:0]      cnt_q;
  logic [1:0]           m_q;
  logic [3:0]           flip_q;
  logic signed [15:0]   last_q [4];
  logic [15:0]          ang_r [4];
  logic [14:0]          spd_r [4];
  logic [15:0]          idle_q, hold_q;
  logic                 ovalid_q;
  logic [127:0]         odata_q;

  // input decode
  logic signed [10:0] in_lx, in_ly, in_rx;
  logic signed [1:0]  in_sp;
  logic signed [15:0] in_hd, in_spin;
  logic               in_acc, in_still, in_hold;

  assign in_lx = s_axis_tdata[10:0];
  assign in_ly = s_axis_tdata[21:11];
  assign in_rx = s_axis_tdata[32:22];
  assign in_sp = s_axis_tdata[34:33];
  assign in_hd = s_axis_tdata[50:35];
  assign in_spin = 16'(in_sp * 16'sd1500) - 16'(in_rx * 16'sd7);
  assign in_still = (in_lx == '0) && (in_ly == '0);
  assign in_hold = in_still && !((in_spin > 16'sd0) || (idle_q == hold_q));
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;

  // shared CORDIC stage
  logic                 ccw, turn_mode;
  logic signed [VW-1:0] xs, ys, atan_v, cx, cy, cz;
  assign turn_mode = (state_q == ST_TITER);
  assign ccw = turn_mode ? (z_q >= 0) : (y_q <= 0);
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign atan_v = atan_lut(5'(cnt_q));
  assign cx = ccw ? x_q - ys : x_q + ys;
  assign cy = ccw ? y_q + xs : y_q - xs;
  assign cz = ccw ? z_q - atan_v : z_q + atan_v;

  // shared multiplier with rounding
  logic signed [VW-1:0]   mul_a;
  logic [29:0]            mul_k;
  logic signed [VW+30:0]  prod, prod30, prod14;
  always_comb begin
    mul_a = x_q;
    mul_k = InvKQ30;
    unique case (state_q)
      ST_TMY:  mul_a = y_q;
      ST_QMUL: begin
        mul_a = VW'(spin_q);
        mul_k = ISq2Q30;
      end
      default: mul_a = x_q;
    endcase
  end
  assign prod = mul_a * $signed({1'b0, mul_k});
  assign prod30 = (prod + (65'sd1 <<< 29)) >>> 30;
  assign prod14 = (prod + (65'sd1 <<< 13)) >>> 14;

  // module vector
  logic signed [VW-1:0] mvx, mvy;
  always_comb begin
    mvx = -(fx_q + q_q);
    mvy = fy_q + q_q;
    unique case (m_q)
      2'd0: begin mvx = -(fx_q - q_q); mvy = fy_q - q_q; end
      2'd1: begin mvx = -(fx_q + q_q); mvy = fy_q - q_q; end
      2'd2: begin mvx = -(fx_q + q_q); mvy = fy_q + q_q; end
      default: begin mvx = -(fx_q - q_q); mvy = fy_q + q_q; end
    endcase
  end

  // per-module finish
  logic signed [16:0] dd, ad, alt;
  logic               fl_t, nf;
  logic signed [17:0] sp18, sps;
  logic signed [18:0] ang0, ang1;
  always_comb begin
    dd = 17'(dir_q) - 17'(last_q[m_q]);
    ad = (dd < 0) ? -dd : dd;
    alt = 17'sd36000 - ad;
    if (alt < ad) ad = alt;
    fl_t = ad > 17'sd9000;
    nf = flip_q[m_q] ^ fl_t;
    sp18 = 18'((len_q + 34'sd32768) >>> 16);
    if (sp18 > SpeedMax) sp18 = SpeedMax;
    sps = nf ? -sp18 : sp18;
    ang0 = 19'(dir_q) + 19'sd63000 + (nf ? 19'sd18000 : 19'sd0);
    if (ang0 >= 19'sd72000) ang1 = ang0 - 19'sd72000;
    else if (ang0 >= 19'sd36000) ang1 = ang0 - 19'sd36000;
    else ang1 = ang0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && !in_hold) state_d = in_still ? ST_QMUL : ST_TWRAP;
      ST_TWRAP: state_d = ST_TQUAD;
      ST_TQUAD: state_d = ST_TITER;
      ST_TITER: if (cnt_q == CntLast) state_d = ST_TMX;
      ST_TMX:   state_d = ST_TMY;
      ST_TMY:   state_d = ST_QMUL;
      ST_QMUL:  state_d = ST_MLOAD;
      ST_MLOAD: state_d = ST_MPRE;
      ST_MPRE:  state_d = (x_q == '0 && y_q == '0) ? ST_MFIN : ST_MITER;
      ST_MITER: if (cnt_q == CntLast) state_d = ST_MLEN;
      ST_MLEN:  state_d = ST_MFIN;
      ST_MFIN:  state_d = (m_q == 2'd3) ? ST_OUT : ST_MLOAD;
      ST_OUT:   if (!ovalid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hold_q <= HoldTicksRst;
      idle_q <= '0;
      flip_q <= 4'b0110;
      last_q[0] <= -16'sd4500;
      last_q[1] <= -16'sd13500;
      last_q[2] <= 16'sd13500;
      last_q[3] <= 16'sd4500;
      ovalid_q <= 1'b0;
      cnt_q <= '0;
      m_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) hold_q <= cfg_data_i;
      if (state_q == ST_OUT && (!ovalid_q || m_axis_tready)) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            spin_q <= in_spin;
            m_q <= '0;
            cnt_q <= '0;
            if (in_hold) begin
              idle_q <= idle_q + 16'd1;
            end else if (in_still) begin
              fx_q <= '0;
              fy_q <= '0;
            end else begin
              idle_q <= '0;
              x_q <= VW'(in_lx) * 34'sd163840;
              y_q <= VW'(in_ly) * 34'sd163840;
              z_q <= -(VW'(in_hd) <<< 16);
            end
          end
        end
        ST_TWRAP: begin
          if (z_q >= Deg180) z_q <= z_q - Deg360;
          else if (z_q < -Deg180) z_q <= z_q + Deg360;
        end
        ST_TQUAD: begin
          if (z_q > Deg90) begin
            x_q <= -y_q; y_q <= x_q; z_q <= z_q - Deg90;
          end else if (z_q < -Deg90) begin
            x_q <= y_q; y_q <= -x_q; z_q <= z_q + Deg90;
          end
        end
        ST_TITER, ST_MITER: begin
          x_q <= cx; y_q <= cy; z_q <= cz;
          cnt_q <= (cnt_q == CntLast) ? '0 : cnt_q + 1'b1;
        end
        ST_TMX: fx_q <= prod30[VW-1:0];
        ST_TMY: fy_q <= prod30[VW-1:0];
        ST_QMUL: q_q <= (spin_q == '0) ? 34'sd1 : prod14[VW-1:0];
        ST_MLOAD: begin
          x_q <= mvx; y_q <= mvy; z_q <= '0;
        end
        ST_MPRE: begin
          if (x_q == '0 && y_q == '0) begin
            dir_q <= '0; len_q <= '0;
          end else if (x_q < 0) begin
            if (y_q >= 0) begin
              x_q <= y_q; y_q <= -x_q; z_q <= Deg90;
            end else begin
              x_q <= -y_q; y_q <= x_q; z_q <= -Deg90;
            end
          end
        end
        ST_MLEN: begin
          len_q <= prod30[VW-1:0];
          dir_q <= 16'((z_q + 34'sd32768) >>> 16);
        end
        ST_MFIN: begin
          flip_q[m_q] <= nf;
          last_q[m_q] <= dir_q;
          ang_r[m_q] <= ang1[15:0];
          spd_r[m_q] <= sps[14:0];
          m_q <= m_q + 2'd1;
        end
        ST_OUT: begin
          if (!ovalid_q || m_axis_tready) begin
            odata_q <= {4'b0, spd_r[3], spd_r[2], spd_r[1], spd_r[0],
                        ang_r[3], ang_r[2], ang_r[1], ang_r[0]};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sim/swerve_drive_kinematics_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for swerve_drive_kinematics: drives control ticks,
// predicts the four steer angles and wheel speeds, checks every output beat.
// Depends on the RTL top level only.
module swerve_drive_kinematics_tb;

  localparam int     Steps       = 16;
  localparam longint Deg90       = 64'd9000 << 16;
  localparam longint Deg180      = 64'd18000 << 16;
  localparam longint Deg360      = 64'd36000 << 16;
  localparam longint InvK        = 64'd652032874;
  localparam longint InvSqrt2    = 64'd759250125;
  localparam longint SpeedLimit  = 8500;
  localparam int     StallLimit  = 20000;
  localparam int     SettleCyc   = 200;
  localparam int     RandomTicks = 550;

  localparam longint ArcTab [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865,
    11730358, 5866610, 2933484, 1466765, 733385,
    366693, 183346, 91673, 45837, 22918, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45
  };
  localparam longint DiagX [4] = '{-1, 1, 1, -1};
  localparam longint DiagY [4] = '{-1, -1, 1, 1};

  typedef struct packed {
    logic [3:0][15:0] angle;
    logic [3:0][14:0] speed;
  } wheel_cmd_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  swerve_drive_kinematics dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  bit          flip_st [4];
  shortint     dir_st [4];
  logic [15:0] idle_cnt;
  logic [15:0] hold_cfg;

  wheel_cmd_t  cmd_q[$];
  int          errors = 0;
  int          beats_seen = 0;
  int          ticks_sent = 0;
  int          stall_cyc = 0;
  bit          gaps_on = 1'b1;
  bit          long_hold = 1'b0;

  function automatic longint round_sh(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic void cordic_rotate(inout longint x, inout longint y, input longint a);
    longint t, nx, ny;
    a = a % Deg360;
    if (a >= Deg180) a -= Deg360;
    if (a < -Deg180) a += Deg360;
    if (a > Deg90) begin
      t = x; x = -y; y = t; a -= Deg90;
    end else if (a < -Deg90) begin
      t = x; x = y; y = -t; a += Deg90;
    end
    for (int i = 0; i < Steps; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); a -= ArcTab[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); a += ArcTab[i];
      end
      x = nx; y = ny;
    end
    x = round_sh(x * InvK, 30);
    y = round_sh(y * InvK, 30);
  endfunction

  function automatic void cordic_vector(input longint x, input longint y,
                                        output longint dir, output longint len);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) begin
      dir = 0; len = 0;
      return;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = Deg90;
      end else begin
        t = x; x = -y; y = t; z = -Deg90;
      end
    end
    for (int i = 0; i < Steps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ArcTab[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ArcTab[i];
      end
      x = nx; y = ny;
    end
    dir = round_sh(z, 16);
    len = round_sh(x * InvK, 30);
  endfunction

  // One control tick through the kinematics; returns 1 when a beat is due.
  function automatic bit predict_wheels(input logic [55:0] tick, output wheel_cmd_t cmd);
    longint lx, ly, rx, sp, hd, spin, fx, fy, q, dir, len, d, spd, ang;
    bit still;
    lx = longint'($signed(tick[10:0]));
    ly = longint'($signed(tick[21:11]));
    rx = longint'($signed(tick[32:22]));
    sp = longint'($signed(tick[34:33]));
    hd = longint'($signed(tick[50:35]));
    spin = sp * 1500 - rx * 7;
    fx = 0;
    fy = 0;
    cmd = '0;
    still = (lx == 0 && ly == 0);
    if (still) begin
      if (!(spin > 0 || idle_cnt == hold_cfg)) begin
        idle_cnt = idle_cnt + 16'd1;
        return 1'b0;
      end
    end else begin
      idle_cnt = '0;
      fx = lx * 5 * 32768;
      fy = ly * 5 * 32768;
      cordic_rotate(fx, fy, -hd * 65536);
    end
    // zero spin still leaves a one-LSB diagonal
    q = (spin == 0) ? 1 : round_sh(spin * 65536 * InvSqrt2, 30);
    for (int m = 0; m < 4; m++) begin
      cordic_vector(-(fx + DiagX[m] * q), fy + DiagY[m] * q, dir, len);
      d = dir - longint'(dir_st[m]);
      if (d < 0) d = -d;
      if (36000 - d < d) d = 36000 - d;
      if (d > 9000) flip_st[m] = !flip_st[m];
      dir_st[m] = shortint'(dir);
      spd = round_sh(len, 16);
      if (spd > SpeedLimit) spd = SpeedLimit;
      ang = (dir % 36000) + 36000 + 27000;
      if (flip_st[m]) begin
        ang += 18000;
        spd = -spd;
      end
      ang = ang % 36000;
      cmd.angle[m] = ang[15:0];
      cmd.speed[m] = spd[14:0];
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int m, longint exp_v, longint got_v);
    $display("MISMATCH beat %0d %s[%0d]: expected %0d, got %0d",
             beats_seen, what, m + 1, exp_v, got_v);
    errors++;
  endtask

  // output checker
  always @(posedge clk_i) begin
    wheel_cmd_t exp_c, got_c;
    if (m_axis_tvalid && m_axis_tready) begin
      for (int m = 0; m < 4; m++) begin
        got_c.angle[m] = m_axis_tdata[16*m +: 16];
        got_c.speed[m] = m_axis_tdata[64 + 15*m +: 15];
      end
      if (cmd_q.size() == 0) begin
        $display("UNEXPECTED beat %0d: no tick pending", beats_seen);
        errors++;
      end else begin
        exp_c = cmd_q.pop_front();
        for (int m = 0; m < 4; m++) begin
          if (got_c.angle[m] !== exp_c.angle[m])
            report_mismatch("steer_angle", m, exp_c.angle[m], got_c.angle[m]);
          if (got_c.speed[m] !== exp_c.speed[m])
            report_mismatch("wheel_speed", m, $signed(exp_c.speed[m]),
                            $signed(got_c.speed[m]));
        end
      end
      beats_seen++;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cyc <= 0;
    else
      stall_cyc <= stall_cyc + 1;
    if (stall_cyc >= StallLimit) begin
      $display("Timeout: no handshake for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random holds per beat, plus one long hold on request
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        w = gaps_on ? $urandom_range(0, 4) : 0;
        if (w > 0) begin
          m_axis_tready <= 1'b0;
          repeat (w) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Sends one tick; returns at the accept edge with valid still high.
  task automatic send_tick(logic [10:0] lx, logic [10:0] ly, logic [10:0] rx,
                           logic [1:0] sp, logic [15:0] hd);
    int w;
    wheel_cmd_t c;
    logic [55:0] tick;
    w = gaps_on ? $urandom_range(0, 4) : 0;
    tick = {5'b0, hd, sp, rx, ly, lx};
    if (w > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tick;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_wheels(tick, c)) cmd_q.push_back(c);
    ticks_sent++;
  endtask

  // Lowers valid at the accept edge, then waits for all beats and the pipe.
  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_hold_ticks(logic [15:0] v);
    drain_all();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    hold_cfg = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_tick(11'sd660, 11'sd660, 11'sd0, 2'sd0, 16'sd0);
    send_tick(-11'sd660, -11'sd660, 11'sd0, 2'sd0, 16'sd0);
    send_tick(11'sd660, -11'sd660, -11'sd660, 2'sd1, 16'sd18000);
    send_tick(-11'sd660, 11'sd660, 11'sd660, -2'sd1, -16'sd18000);
    send_tick(11'sd1, 11'sd0, 11'sd0, 2'sd0, 16'sd9000);
    send_tick(11'sd0, 11'sd1, 11'sd0, 2'sd0, -16'sd9000);
    // heading far beyond half a turn
    send_tick(11'sd300, -11'sd200, 11'sd5, 2'sd0, 16'h7fff);
    send_tick(-11'sd300, 11'sd200, -11'sd5, 2'sd1, 16'h8000);
    // switch pattern outside the legal levels
    send_tick(11'sd100, 11'sd100, 11'sd0, 2'b10, 16'sd4500);
    // raw stick bit extremes, drives speed into saturation
    send_tick(11'h400, 11'h400, 11'h400, 2'sd1, 16'sd0);
    send_tick(11'h3ff, 11'h3ff, 11'h400, 2'sd1, 16'sd1234);
    // no translation, positive spin
    send_tick(11'sd0, 11'sd0, 11'sd0, 2'sd1, 16'sd0);
    send_tick(11'sd0, 11'sd0, -11'sd660, 2'sd1, 16'sd0);
    send_tick(11'sd0, 11'sd0, -11'sd1, 2'sd0, 16'sd0);
    // no translation, zero and negative spin: held
    send_tick(11'sd0, 11'sd0, 11'sd0, 2'sd0, 16'sd0);
    send_tick(11'sd0, 11'sd0, 11'sd660, -2'sd1, 16'sd0);
    // zero spin with translation
    send_tick(11'sd50, -11'sd70, 11'sd0, 2'sd0, 16'sd2000);
    send_tick(11'sd1, 11'sd1, 11'sd0, 2'sd0, 16'sd0);
    drain_all();
  endtask

  task automatic test_hold_counter();
    set_hold_ticks(16'd3);
    for (int i = 0; i < 7; i++) send_tick('0, '0, 11'sd10, 2'sd0, 16'($urandom));
    send_tick(11'sd20, 11'sd0, 11'sd0, 2'sd0, 16'sd0);
    for (int i = 0; i < 5; i++) send_tick('0, '0, 11'sd0, -2'sd1, 16'sd0);
    set_hold_ticks(16'd0);
    for (int i = 0; i < 3; i++) send_tick('0, '0, 11'sd0, 2'sd0, 16'sd100);
    set_hold_ticks(16'hffff);
    for (int i = 0; i < 4; i++) send_tick('0, '0, 11'sd0, 2'sd0, 16'sd0);
    send_tick(11'sd0, -11'sd5, 11'sd0, 2'sd0, 16'sd0);
    drain_all();
  endtask

  task automatic random_tick();
    int kind;
    logic [10:0] lx, ly, rx;
    logic [1:0]  sp;
    logic [15:0] hd;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      lx = 11'($urandom); ly = 11'($urandom); rx = 11'($urandom);
      sp = 2'($urandom);  hd = 16'($urandom);
    end else begin
      lx = 11'($signed($urandom_range(0, 1320)) - 660);
      ly = 11'($signed($urandom_range(0, 1320)) - 660);
      rx = 11'($signed($urandom_range(0, 1320)) - 660);
      sp = 2'($signed($urandom_range(0, 2)) - 1);
      hd = 16'($signed($urandom_range(0, 36000)) - 18000);
      if (kind < 25) begin
        lx = '0; ly = '0;
      end else if (kind < 30) begin
        lx = '0;
      end
    end
    send_tick(lx, ly, rx, sp, hd);
  endtask

  task automatic test_random();
    logic [15:0] hv;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: hv = 16'd500;
        1: hv = 16'($urandom_range(1, 12));
        2: hv = 16'd0;
        3: hv = 16'hffff;
        default: hv = 16'($urandom);
      endcase
      set_hold_ticks(hv);
      gaps_on = (ph != 2);
      for (int i = 0; i < RandomTicks / 5; i++) random_tick();
    end
    gaps_on = 1'b1;
    drain_all();
  endtask

  task automatic test_backpressure();
    set_hold_ticks(16'd2);
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++)
      send_tick(11'($signed($urandom_range(0, 400)) - 200), 11'sd300,
                11'($urandom_range(0, 50)), 2'sd1, 16'($urandom_range(0, 9000)));
    drain_all();
    for (int i = 0; i < 8; i++) random_tick();
    drain_all();
  endtask

  initial begin
    for (int m = 0; m < 4; m++) begin
      flip_st[m] = (m == 1 || m == 2);
    end
    dir_st[0] = -4500; dir_st[1] = -13500; dir_st[2] = 13500; dir_st[3] = 4500;
    idle_cnt = '0;
    hold_cfg = 16'd500;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_hold_counter();
    test_backpressure();
    test_random();
    $display("Sent %0d ticks, checked %0d beats over hold_ticks 0..65535,",
             ticks_sent, beats_seen);
    $display("with random gaps, a long output stall and out-of-range fields.");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
